[design/elb_pkg.sv]
// Shared types, codes and sizes for the endpoint load balancer.
// Used by elb_count_ram and endpoint_load_balancer; depends on nothing.
package elb_pkg;

    localparam int ENDPOINTS   = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = $clog2(ENDPOINTS);
    localparam int N_W         = $clog2(ENDPOINTS + 1);
    localparam int EP_W        = 4;
    localparam int CHOSEN_W    = 4;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int ECOUNT_W    = 5;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic ACT_SELECT  = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic MODE_RR = 1'b0;
    localparam logic MODE_LC = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(1);

    localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_RANGE = STATUS_W'(2);

    typedef struct packed {
        logic            action;
        logic [EP_W-1:0] endpoint;
    } in_word_t;

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    typedef struct packed {
        logic                   clear;
        logic [IDX_W-1:0]       rd_addr;
        logic                   wr_en;
        logic [IDX_W-1:0]       wr_addr;
        logic [COUNT_WIDTH-1:0] wr_data;
    } ram_req_t;

endpackage

[design/elb_count_ram.sv]
// Open-connection count store: one port read with registered data, one write port.
// Per-entry valid bits make a cleared entry read as zero. Depends on elb_pkg.
module elb_count_ram (
    input  logic                            clk,
    input  logic                            rst_n,
    input  elb_pkg::ram_req_t               req,
    output logic [elb_pkg::COUNT_WIDTH-1:0] rd_data
);
    import elb_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [ENDPOINTS];
    logic [ENDPOINTS-1:0]   valid_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[req.rd_addr] && !req.clear;
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[design/endpoint_load_balancer.sv]
// Endpoint load balancer top level: round-robin pointer and least-connections search.
// Sequencer around one shared compare unit and elb_count_ram. Depends on elb_pkg.
//
//  Channel  Signals                       Word / fields
//  input    in_valid, in_ready, in_data   action, endpoint
//  output   out_valid, out_ready, out_data chosen, status
//  config   cfg_we, cfg_index, cfg_data   mode (index 0), endpoint_count (index 1)
//
// A round-robin select or any release that needs no count goes from idle straight to done.
// A least-connections release makes one count read, then the update.
// A least-connections select scans the effective endpoint count (1 to 16) of entries;
// the scan reads one count per cycle through the single read port and one comparator.
// in_ready is high only while the sequencer is idle; a waiting result holds the sequencer
// until the output register frees. Reset and mode or count writes clear all counts.
module endpoint_load_balancer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  elb_pkg::in_word_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output elb_pkg::out_word_t               out_data,
    input  logic                             cfg_we,
    input  logic [elb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [elb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import elb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic                   mode_reg;
    logic [ECOUNT_W-1:0]    ecount_reg;
    logic [IDX_W-1:0]       ptr_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [COUNT_WIDTH-1:0] best_cnt_reg;
    logic [EP_W-1:0]        ep_reg;
    out_word_t              res_reg;
    out_word_t              out_data_reg;
    logic                   out_valid_reg;

    logic [N_W-1:0]         eff_n;
    logic                   in_fire;
    logic                   cfg_hit;
    logic                   take;
    logic                   scan_last;
    logic [COUNT_WIDTH-1:0] win_cnt;
    logic [IDX_W-1:0]       win_idx;
    logic [COUNT_WIDTH-1:0] ram_rd_data;
    ram_req_t               ram_req;

    always_comb
    begin
        if (ecount_reg == '0)
        begin
            eff_n = N_W'(1);
        end
        else if (N_W'(ecount_reg) > N_W'(ENDPOINTS))
        begin
            eff_n = N_W'(ENDPOINTS);
        end
        else
        begin
            eff_n = N_W'(ecount_reg);
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_hit   = cfg_we && ((cfg_index == CFG_MODE) || (cfg_index == CFG_COUNT));
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign take      = (rd_idx_reg == '0) || (ram_rd_data < best_cnt_reg);
    assign win_cnt   = take ? ram_rd_data : best_cnt_reg;
    assign win_idx   = take ? rd_idx_reg : best_idx_reg;
    assign scan_last = (N_W'(rd_idx_reg) + N_W'(1)) >= eff_n;

    always_comb
    begin
        ram_req         = '0;
        ram_req.clear   = cfg_hit;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_req.rd_addr = (in_data.action == ACT_RELEASE)
                                  ? IDX_W'(in_data.endpoint) : '0;
            end
            ST_SCAN:
            begin
                ram_req.rd_addr = rd_idx_reg + IDX_W'(1);
            end
            ST_WRITE:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = best_idx_reg;
                ram_req.wr_data = (best_cnt_reg == COUNT_MAX)
                                  ? best_cnt_reg : best_cnt_reg + COUNT_WIDTH'(1);
            end
            ST_CHECK:
            begin
                ram_req.wr_en   = (ram_rd_data != '0);
                ram_req.wr_addr = IDX_W'(ep_reg);
                ram_req.wr_data = ram_rd_data - COUNT_WIDTH'(1);
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    elb_count_ram u_count_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_RR;
            ecount_reg    <= ECOUNT_W'(1);
            ptr_reg       <= '0;
            rd_idx_reg    <= '0;
            best_idx_reg  <= '0;
            best_cnt_reg  <= '0;
            ep_reg        <= '0;
            res_reg       <= '0;
            out_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_hit)
            begin
                ptr_reg <= '0;
                if (cfg_index == CFG_MODE)
                begin
                    mode_reg <= cfg_data[0];
                end
                else
                begin
                    ecount_reg <= ECOUNT_W'(cfg_data);
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        ep_reg <= in_data.endpoint;
                        if (in_data.action == ACT_SELECT)
                        begin
                            if (mode_reg == MODE_RR)
                            begin
                                res_reg.chosen <= CHOSEN_W'(ptr_reg);
                                res_reg.status <= STATUS_OK;
                                if ((N_W'(ptr_reg) + N_W'(1)) >= eff_n)
                                begin
                                    ptr_reg <= '0;
                                end
                                else
                                begin
                                    ptr_reg <= ptr_reg + IDX_W'(1);
                                end
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                rd_idx_reg <= '0;
                                state_reg  <= ST_SCAN;
                            end
                        end
                        else
                        begin
                            res_reg.chosen <= in_data.endpoint;
                            if (N_W'(in_data.endpoint) >= eff_n)
                            begin
                                res_reg.status <= STATUS_RANGE;
                                state_reg      <= ST_DONE;
                            end
                            else if (mode_reg == MODE_RR)
                            begin
                                res_reg.status <= STATUS_OK;
                                state_reg      <= ST_DONE;
                            end
                            else
                            begin
                                state_reg <= ST_CHECK;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    best_cnt_reg <= win_cnt;
                    best_idx_reg <= win_idx;
                    rd_idx_reg   <= rd_idx_reg + IDX_W'(1);
                    if (scan_last)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    res_reg.chosen <= CHOSEN_W'(best_idx_reg);
                    res_reg.status <= STATUS_OK;
                    state_reg      <= ST_DONE;
                end
                ST_CHECK:
                begin
                    res_reg.status <= (ram_rd_data == '0) ? STATUS_EMPTY : STATUS_OK;
                    state_reg      <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg  <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The sequencer takes no new word in the cycle after accepting one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input accepted while sequencer busy");

    // An ok result always names an endpoint in use.
    a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == STATUS_OK)) |-> (N_W'(out_data.chosen) < eff_n))
        else $error("ok result names an endpoint out of range");

    // A range error is reported only for an index beyond the endpoints in use.
    a_range_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == STATUS_RANGE)) |-> (N_W'(out_data.chosen) >= eff_n))
        else $error("range status on an in-range endpoint");

    // Empty-release status can only come from least-connections mode.
    a_empty_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == STATUS_EMPTY)) |-> (mode_reg == MODE_LC))
        else $error("empty release reported in round-robin mode");

endmodule
